// File: rtl/ipv4hc_pkg.sv
`timescale 1ns / 1ps

package ipv4hc_pkg;

    typedef logic [2:0] status_t;

    localparam status_t STATUS_ACCEPT      = 3'd0;
    localparam status_t STATUS_VERSION_ERR = 3'd1;
    localparam status_t STATUS_LENGTH_ERR  = 3'd2;
    localparam status_t STATUS_TTL_ERR     = 3'd3;
    localparam status_t STATUS_CSUM_ERR    = 3'd4;
    localparam status_t STATUS_DEST_ERR    = 3'd5;

    localparam int          APB_ADDR_W         = 3;
    localparam logic [2:0]  LOCAL_ADDRESS_ADDR = 3'd0;

    localparam logic [4:0]  WORD_VER_IHL  = 5'd0;
    localparam logic [4:0]  WORD_TOT_LEN  = 5'd1;
    localparam logic [4:0]  WORD_TTL      = 5'd4;
    localparam logic [4:0]  WORD_DEST_HI  = 5'd8;
    localparam logic [4:0]  WORD_DEST_LO  = 5'd9;

    localparam logic [3:0]  IPV4_VERSION  = 4'd4;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [15:0] CSUM_GOOD     = 16'hffff;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

// File: rtl/ipv4_header_checker.sv
`timescale 1ns / 1ps

// Receive-side IPv4 header checker. Header words (big-endian, 16 bits) are
// taken at one per cycle with no gaps required; each accepted word sits in an
// input register, where a single pass of logic folds it into the ones'
// complement checksum and captures the header fields. When the last header
// word (IHL*2 words, or the first word if IHL is below 5) passes that stage,
// one verdict is loaded into the output register once that register is free.
// A waiting verdict stalls input only when the word behind it would produce
// another verdict. local_address is written over the APB port at byte
// address 0 and should only be changed while no header is in flight.
module ipv4_header_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ipv4hc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [15:0]                          header_word,
    input  logic                                 word_start,
    input  logic [15:0]                          packet_length,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ipv4hc_pkg::status_t                  status,
    output logic [5:0]                           header_bytes,
    output logic [15:0]                          payload_length
);

    import ipv4hc_pkg::*;

    logic [31:0] local_address_reg;

    logic        s1_valid_reg;
    logic [15:0] s1_word_reg;
    logic        s1_start_reg;
    logic [15:0] s1_plen_reg;

    logic [4:0]  word_count_reg;
    logic [15:0] checksum_acc_reg;
    logic [3:0]  version_value_reg;
    logic [3:0]  ihl_value_reg;
    logic [15:0] total_len_reg;
    logic [7:0]  ttl_value_reg;
    logic [31:0] dest_addr_reg;
    logic [15:0] reported_len_reg;
    logic        in_header_reg;

    logic        out_valid_reg;
    status_t     status_reg;
    logic [5:0]  header_bytes_reg;
    logic [15:0] payload_length_reg;

    logic [4:0]  word_count_next;
    logic [15:0] checksum_acc_next;
    logic [3:0]  version_value_next;
    logic [3:0]  ihl_value_next;
    logic [15:0] total_len_next;
    logic [7:0]  ttl_value_next;
    logic [31:0] dest_addr_next;
    logic [15:0] reported_len_next;
    logic        in_header_next;
    status_t     status_next;
    logic [5:0]  header_bytes_next;
    logic [15:0] payload_length_next;

    logic        active;
    logic        emit;
    logic [4:0]  wc;
    logic [5:0]  wc_plus;
    logic        s1_adv;
    logic        out_free;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr == LOCAL_ADDRESS_ADDR) ? local_address_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && pready && (paddr == LOCAL_ADDRESS_ADDR))
        begin
            local_address_reg <= pwdata;
        end
    end

    // per-word processing
    always_comb
    begin
        active             = s1_start_reg || in_header_reg;
        wc                 = s1_start_reg ? 5'd0 : word_count_reg;
        wc_plus            = {1'b0, wc} + 6'd1;
        reported_len_next  = s1_start_reg ? s1_plen_reg : reported_len_reg;
        checksum_acc_next  = ones_add(s1_start_reg ? 16'd0 : checksum_acc_reg, s1_word_reg);
        version_value_next = version_value_reg;
        ihl_value_next     = ihl_value_reg;
        total_len_next     = total_len_reg;
        ttl_value_next     = ttl_value_reg;
        dest_addr_next     = dest_addr_reg;

        case (wc)
            WORD_VER_IHL:
            begin
                version_value_next = s1_word_reg[15:12];
                ihl_value_next     = s1_word_reg[11:8];
            end
            WORD_TOT_LEN: total_len_next = s1_word_reg;
            WORD_TTL:     ttl_value_next = s1_word_reg[15:8];
            WORD_DEST_HI: dest_addr_next = {s1_word_reg, dest_addr_reg[15:0]};
            WORD_DEST_LO: dest_addr_next = {dest_addr_reg[31:16], s1_word_reg};
            default:      ;
        endcase

        header_bytes_next   = {ihl_value_next, 2'b00};
        emit                = 1'b0;
        word_count_next     = wc;
        status_next         = STATUS_ACCEPT;
        payload_length_next = 16'd0;

        if (active)
        begin
            if ((wc == WORD_VER_IHL) && (ihl_value_next < IHL_MIN))
            begin
                emit        = 1'b1;
                status_next = (version_value_next != IPV4_VERSION) ? STATUS_VERSION_ERR
                                                                   : STATUS_LENGTH_ERR;
            end
            else if (wc_plus < {1'b0, ihl_value_next, 1'b0})
            begin
                word_count_next = wc_plus[4:0];
            end
            else
            begin
                emit = 1'b1;
                if (version_value_next != IPV4_VERSION)
                begin
                    status_next = STATUS_VERSION_ERR;
                end
                else if ((total_len_next != reported_len_next) ||
                         (total_len_next < {10'd0, header_bytes_next}))
                begin
                    status_next = STATUS_LENGTH_ERR;
                end
                else if (ttl_value_next == 8'd0)
                begin
                    status_next = STATUS_TTL_ERR;
                end
                else if (checksum_acc_next != CSUM_GOOD)
                begin
                    status_next = STATUS_CSUM_ERR;
                end
                else if (dest_addr_next != local_address_reg)
                begin
                    status_next = STATUS_DEST_ERR;
                end
                else
                begin
                    status_next         = STATUS_ACCEPT;
                    payload_length_next = reported_len_next - {10'd0, header_bytes_next};
                end
            end
        end

        in_header_next = active && !emit;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && (!emit || out_free);
    assign in_ready = !s1_valid_reg || s1_adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_word_reg  <= header_word;
            s1_start_reg <= word_start;
            s1_plen_reg  <= packet_length;
        end
    end

    // header state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg    <= 5'd0;
            checksum_acc_reg  <= 16'd0;
            version_value_reg <= 4'd0;
            ihl_value_reg     <= 4'd0;
            total_len_reg     <= 16'd0;
            ttl_value_reg     <= 8'd0;
            dest_addr_reg     <= 32'd0;
            reported_len_reg  <= 16'd0;
            in_header_reg     <= 1'b0;
        end
        else if (s1_adv && active)
        begin
            word_count_reg    <= word_count_next;
            checksum_acc_reg  <= checksum_acc_next;
            version_value_reg <= version_value_next;
            ihl_value_reg     <= ihl_value_next;
            total_len_reg     <= total_len_next;
            ttl_value_reg     <= ttl_value_next;
            dest_addr_reg     <= dest_addr_next;
            reported_len_reg  <= reported_len_next;
            in_header_reg     <= in_header_next;
        end
    end

    // verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            status_reg         <= status_next;
            header_bytes_reg   <= header_bytes_next;
            payload_length_reg <= payload_length_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign header_bytes   = header_bytes_reg;
    assign payload_length = payload_length_reg;

    a_payload_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STATUS_ACCEPT) |-> payload_length_reg == 16'd0)
        else $error("payload length not zero on rejected header");

    a_accept_min_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == STATUS_ACCEPT) |-> header_bytes_reg >= 6'd20)
        else $error("accepted header shorter than 20 bytes");

    a_word_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_header_reg |-> word_count_reg < 5'd30)
        else $error("word count beyond longest header");

    a_no_verdict_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_adv && emit && out_valid_reg && !out_ready))
        else $error("verdict overwritten before transfer");

endmodule
